[rtl/ictf_pkg.sv]
// Shared types, constants and the arctangent table of the tilt filter.
`default_nettype none
package ictf_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_TAB_LEN = 24;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_TAB_LEN) ? CORDIC_STEPS : ATAN_TAB_LEN;
  localparam int ITER_W       = $clog2(ATAN_TAB_LEN + 1);

  localparam int ANG_W  = 25;   // angle, 1/65536 degree
  localparam int CRD_W  = 27;   // CORDIC x / y datapath
  localparam int MUL_W  = 27;   // shared multiplier operands
  localparam int ACC_W  = 48;   // multiply-accumulate result
  localparam int RAD_W  = 48;   // square root radicand
  localparam int ROOT_W = 24;

  localparam logic signed [ANG_W-1:0] ANGLE_MAX = 25'sd11796480;
  localparam logic signed [ACC_W-1:0] RND_HALF  = 48'sd32768;
  localparam logic [16:0] BLEND_ONE   = 17'd65536;
  localparam logic [16:0] BLEND_RST   = 17'd62915;
  localparam logic [23:0] GAIN_RST    = 24'd1047553;

  localparam logic REG_BLEND = 1'b0;
  localparam logic REG_GAIN  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQA, ST_SQB, ST_SQW, ST_SQS, ST_ROOT, ST_CST, ST_CORD,
    ST_GYR, ST_GW1, ST_GW2, ST_BLA, ST_BLB, ST_BW1, ST_BW2, ST_DONE
  } seq_state_t;

  function automatic logic [21:0] atan_deg(input logic [ITER_W-1:0] idx);
    logic [21:0] v;
    case (idx)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[rtl/ictf_mac.sv]
// Shared signed multiplier with registered product and accumulator.
`default_nettype none
module ictf_mac (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               issue,
  input  wire logic                               first,
  input  wire logic signed [ictf_pkg::MUL_W-1:0]  op_a,
  input  wire logic signed [ictf_pkg::MUL_W-1:0]  op_b,
  output logic signed [ictf_pkg::ACC_W-1:0]       acc
);
  import ictf_pkg::*;

  logic signed [2*MUL_W-1:0] full_prod;
  logic signed [ACC_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic                      pv_r;
  logic                      pf_r;

  assign full_prod = op_a * op_b;
  assign acc       = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
      pf_r <= 1'b0;
    end else begin
      pv_r <= issue;
      pf_r <= first;
    end
    if (issue) begin
      prod_r <= full_prod[ACC_W-1:0];
    end
    if (pv_r) begin
      acc_r <= pf_r ? prod_r : acc_r + prod_r;
    end
  end

endmodule
`default_nettype wire

[rtl/ictf_sqrt.sv]
// Bit-serial integer square root, one result bit per cycle.
`default_nettype none
module ictf_sqrt (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [ictf_pkg::RAD_W-1:0]  radicand,
  output logic                             busy,
  output logic [ictf_pkg::ROOT_W-1:0]      root
);
  import ictf_pkg::*;

  logic [RAD_W-1:0]  n_r;
  logic [ROOT_W+2:0] rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [4:0]        cnt_r;
  logic              busy_r;
  logic [ROOT_W+2:0] rem_t;
  logic [ROOT_W+2:0] trial;
  logic              take;

  assign rem_t = {rem_r[ROOT_W:0], n_r[RAD_W-1 -: 2]};
  assign trial = {1'b0, root_r, 2'b01};
  assign take  = (rem_t >= trial);
  assign busy  = busy_r;
  assign root  = root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 5'(ROOT_W - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        busy_r <= 1'b0;
      end
    end
    if (start) begin
      n_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      n_r    <= {n_r[RAD_W-3:0], 2'b00};
      rem_r  <= take ? rem_t - trial : rem_t;
      root_r <= {root_r[ROOT_W-2:0], take};
    end
  end

endmodule
`default_nettype wire

[rtl/ictf_cordic.sv]
// Iterative CORDIC vectoring unit, one micro-rotation per cycle.
`default_nettype none
module ictf_cordic (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire logic signed [ictf_pkg::CRD_W-1:0]  x_in,
  input  wire logic signed [ictf_pkg::CRD_W-1:0]  y_in,
  output logic                                    busy,
  output logic signed [ictf_pkg::ANG_W-1:0]       angle
);
  import ictf_pkg::*;

  logic signed [CRD_W-1:0] x_r;
  logic signed [CRD_W-1:0] y_r;
  logic signed [ANG_W-1:0] z_r;
  logic [ITER_W-1:0]       i_r;
  logic                    busy_r;
  logic signed [CRD_W-1:0] dx;
  logic signed [CRD_W-1:0] dy;
  logic signed [ANG_W-1:0] step;

  assign dx    = y_r >>> i_r;
  assign dy    = x_r >>> i_r;
  assign step  = $signed({3'b000, atan_deg(i_r)});
  assign busy  = busy_r;
  assign angle = z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      i_r    <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      i_r    <= '0;
    end else if (busy_r) begin
      i_r <= i_r + ITER_W'(1);
      if (i_r == ITER_W'(CORDIC_ITERS - 1)) begin
        busy_r <= 1'b0;
      end
    end
    if (start) begin
      x_r <= x_in;
      y_r <= y_in;
      z_r <= '0;
    end else if (busy_r) begin
      if (!y_r[CRD_W-1]) begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + step;
      end else begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - step;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/imu_complementary_tilt_filter.sv]
// Top level: roll/pitch complementary filter on shared sqrt, CORDIC and MAC units.
//
//  channel | direction | ports                                  | handshake
//  --------+-----------+----------------------------------------+------------------
//  in      | sink      | in_accel_x/y/z, in_gyro_x/y            | in_valid/in_stall
//  out     | source    | out_roll_out, out_pitch_out            | out_valid/out_stall
//  cfg     | slave     | psel penable pwrite paddr pwdata       | prdata, pready=1
//
// One sample keeps the block busy, and no new sample is taken until it retires:
// per axis the square MACs, the 24-step root, starting and running the
// CORDIC_STEPS-step vectoring pass and the gyro and blend MACs, roll then
// pitch on the same units, plus retiring into the output register.
// in_stall is high from acceptance until that retire; retire waits only while the
// previous result is still held. Reset clears both estimates and loads defaults.
`default_nettype none
module imu_complementary_tilt_filter (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic signed [15:0]   in_accel_x,
  input  wire logic signed [15:0]   in_accel_y,
  input  wire logic signed [15:0]   in_accel_z,
  input  wire logic signed [15:0]   in_gyro_x,
  input  wire logic signed [15:0]   in_gyro_y,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic signed [24:0]        out_roll_out,
  output logic signed [24:0]        out_pitch_out,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import ictf_pkg::*;

  seq_state_t state_r, state_nxt;

  // Configuration registers
  logic [16:0] blend_r;
  logic [23:0] gain_r;
  logic [16:0] alpha;

  // Captured sample and working values
  logic signed [15:0] ax_r, ay_r, az_r, gx_r, gy_r;
  logic               axis_r;       // 0 = roll, 1 = pitch
  logic               zero_r;       // both atan2 arguments zero
  logic signed [25:0] p_r;
  logic signed [ANG_W-1:0] roll_est_r, pitch_est_r, roll_new_r, pitch_new_r;
  logic               out_valid_r;
  logic signed [ANG_W-1:0] roll_out_r, pitch_out_r;

  // Unit handshakes
  logic                     mac_issue, mac_first;
  logic signed [MUL_W-1:0]  mac_a, mac_b;
  logic signed [ACC_W-1:0]  mac_acc;
  logic                     sqrt_start, sqrt_busy;
  logic [ROOT_W-1:0]        sqrt_root;
  logic                     crd_start, crd_busy;
  logic signed [ANG_W-1:0]  crd_angle;

  // Axis operands
  logic signed [16:0]       num;
  logic signed [15:0]       opa, opb;
  logic signed [15:0]       gyro;
  logic signed [ANG_W-1:0]  est;
  logic signed [ANG_W-1:0]  acc_ang;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [31:0]       scaled;
  logic signed [ANG_W-1:0]  sat;
  logic                     in_xfer, out_xfer, cfg_wr;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_roll_out  = roll_out_r;
  assign out_pitch_out = pitch_out_r;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[2])
      REG_BLEND: prdata = {15'd0, blend_r};
      REG_GAIN:  prdata = {8'd0, gain_r};
      default:   prdata = '0;
    endcase
  end

  assign alpha = (blend_r > BLEND_ONE) ? BLEND_ONE : blend_r;

  // Roll: atan2(-ax, |ay,az|); pitch: atan2(ay, |ax,az|)
  assign num     = axis_r ? 17'(ay_r) : -17'(ax_r);
  assign opa     = axis_r ? ax_r : ay_r;
  assign opb     = az_r;
  assign gyro    = axis_r ? gy_r : gx_r;
  assign est     = axis_r ? pitch_est_r : roll_est_r;
  assign acc_ang = zero_r ? '0 : crd_angle;

  // Round the accumulator to 1/65536 degree
  assign rnd    = mac_acc + RND_HALF;
  assign scaled = rnd[47:16];
  assign sat    = (scaled > 32'(ANGLE_MAX)) ? ANGLE_MAX :
                  (scaled < -32'(ANGLE_MAX)) ? -ANGLE_MAX : scaled[ANG_W-1:0];

  always_comb begin
    state_nxt  = state_r;
    mac_issue  = 1'b0;
    mac_first  = 1'b0;
    mac_a      = '0;
    mac_b      = '0;
    sqrt_start = 1'b0;
    crd_start  = 1'b0;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_SQA;
      ST_SQA: begin
        mac_issue = 1'b1;
        mac_first = 1'b1;
        mac_a     = MUL_W'(opa);
        mac_b     = MUL_W'(opa);
        state_nxt = ST_SQB;
      end
      ST_SQB: begin
        mac_issue = 1'b1;
        mac_a     = MUL_W'(opb);
        mac_b     = MUL_W'(opb);
        state_nxt = ST_SQW;
      end
      ST_SQW: state_nxt = ST_SQS;
      ST_SQS: begin
        sqrt_start = 1'b1;
        state_nxt  = ST_ROOT;
      end
      ST_ROOT: if (!sqrt_busy) state_nxt = ST_CST;
      ST_CST: begin
        crd_start = 1'b1;
        state_nxt = ST_CORD;
      end
      ST_CORD: if (!crd_busy) state_nxt = ST_GYR;
      ST_GYR: begin
        mac_issue = 1'b1;
        mac_first = 1'b1;
        mac_a     = MUL_W'(gyro);
        mac_b     = MUL_W'($signed({1'b0, gain_r}));
        state_nxt = ST_GW1;
      end
      ST_GW1: state_nxt = ST_GW2;
      ST_GW2: state_nxt = ST_BLA;
      ST_BLA: begin
        mac_issue = 1'b1;
        mac_first = 1'b1;
        mac_a     = MUL_W'($signed({1'b0, alpha}));
        mac_b     = MUL_W'(p_r);
        state_nxt = ST_BLB;
      end
      ST_BLB: begin
        mac_issue = 1'b1;
        mac_a     = MUL_W'($signed({1'b0, BLEND_ONE - alpha}));
        mac_b     = MUL_W'(acc_ang);
        state_nxt = ST_BW1;
      end
      ST_BW1: state_nxt = ST_BW2;
      ST_BW2: state_nxt = axis_r ? ST_DONE : ST_SQA;
      ST_DONE: if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      blend_r     <= BLEND_RST;
      gain_r      <= GAIN_RST;
      roll_est_r  <= '0;
      pitch_est_r <= '0;
      out_valid_r <= 1'b0;
      axis_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        if (paddr[2] == REG_BLEND) blend_r <= pwdata[16:0];
        else                       gain_r  <= pwdata[23:0];
      end
      if (in_xfer) begin
        axis_r <= 1'b0;
      end else if (state_r == ST_BW2) begin
        axis_r <= !axis_r;
      end
      // Retire: load output register and commit both estimates
      if (state_r == ST_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
        roll_est_r  <= roll_new_r;
        pitch_est_r <= pitch_new_r;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ax_r <= in_accel_x;
      ay_r <= in_accel_y;
      az_r <= in_accel_z;
      gx_r <= in_gyro_x;
      gy_r <= in_gyro_y;
    end
    if (state_r == ST_CST) begin
      zero_r <= (num == 17'sd0) && (mac_acc == '0);
    end
    // Gyro-advanced estimate p = est + round(gyro * gain / 65536)
    if (state_r == ST_GW2) begin
      p_r <= 26'(est) + scaled[25:0];
    end
    if (state_r == ST_BW2) begin
      if (axis_r) pitch_new_r <= sat;
      else        roll_new_r  <= sat;
    end
    if (state_r == ST_DONE && (!out_valid_r || !out_stall)) begin
      roll_out_r  <= roll_new_r;
      pitch_out_r <= pitch_new_r;
    end
  end

  ictf_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .issue (mac_issue),
    .first (mac_first),
    .op_a  (mac_a),
    .op_b  (mac_b),
    .acc   (mac_acc)
  );

  // Radicand (a^2 + b^2) * 65536; the sum is at most 2^31 and fits 32 unsigned bits
  ictf_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand ({mac_acc[31:0], 16'd0}),
    .busy     (sqrt_busy),
    .root     (sqrt_root)
  );

  ictf_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (crd_start),
    .x_in  (CRD_W'({1'b0, sqrt_root})),
    .y_in  (CRD_W'($signed({num, 8'd0}))),
    .busy  (crd_busy),
    .angle (crd_angle)
  );

endmodule
`default_nettype wire

[rtl/ictf_checker.sv]
// Port-level checks for the tilt filter and their bind to the top level.
`default_nettype none
module ictf_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [24:0] out_roll_out,
  input wire logic signed [24:0] out_pitch_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_roll_out) && $stable(out_pitch_out))
    else $error("stalled result changed");

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a sample is in work");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_roll_out <= 25'sd11796480 && out_roll_out >= -25'sd11796480 &&
                  out_pitch_out <= 25'sd11796480 && out_pitch_out >= -25'sd11796480)
    else $error("angle outside saturation range");

endmodule

bind imu_complementary_tilt_filter ictf_checker u_ictf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_roll_out  (out_roll_out),
  .out_pitch_out (out_pitch_out)
);
`default_nettype wire
